// ===== sv/drive_command_frame_decoder_top_defines.svh =====
// Assertion macros for the drive command frame decoder.
// Used by drive_command_frame_decoder_top.sv; no other dependencies.
`ifndef DRIVE_COMMAND_FRAME_DECODER_TOP_DEFINES_SVH
`define DRIVE_COMMAND_FRAME_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define DCFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define DCFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define DCFD_ASSERT(lbl, prop, msg)
`define DCFD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/dcfd_pkg.sv =====
// Package for the drive command frame decoder: codes, types, constants.
// No dependencies; used by drive_command_frame_decoder_top.
`default_nettype none

package dcfd_pkg;

  // Field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned ElapsedW = 17;
  localparam int unsigned QuoW     = 16;
  localparam int unsigned CntW     = 4;
  localparam logic [CntW-1:0] DivLast = 4'd15;

  // Direction bytes
  localparam logic [7:0] CodeFwd     = 8'hF1;
  localparam logic [7:0] CodeBwd     = 8'hF2;
  localparam logic [7:0] CodeStop    = 8'hF3;
  localparam logic [7:0] CodePan     = 8'hF4;
  localparam logic [7:0] CodeStopAll = 8'hF5;

  // Mapping constants
  localparam logic [7:0] TurnSpeedMin        = 8'd0;
  localparam logic [7:0] DriveSpeedMin       = 8'd0;
  localparam logic [7:0] ForwardThrottleMin  = 8'd0;
  localparam logic [7:0] ForwardThrottleMax  = 8'd255;
  localparam logic [7:0] BackwardThrottleMin = 8'd0;
  localparam logic [7:0] BackwardThrottleMax = 8'd255;

  // Register reset values
  localparam logic [7:0]  RstCenter   = 8'd90;
  localparam logic [7:0]  RstLeftMin  = 8'd0;
  localparam logic [7:0]  RstLeftMax  = 8'd89;
  localparam logic [7:0]  RstRightMin = 8'd91;
  localparam logic [7:0]  RstRightMax = 8'd180;
  localparam logic [7:0]  RstTurnMax  = 8'd255;
  localparam logic [7:0]  RstDriveMax = 8'd255;
  localparam logic [15:0] RstTimeout  = 16'd1000;

  // Motor direction codes (2-bit signed)
  localparam logic [1:0] DirNone = 2'b00;
  localparam logic [1:0] DirFwd  = 2'b01;
  localparam logic [1:0] DirRev  = 2'b11;

  typedef enum logic [2:0] {
    REG_CENTER    = 3'd0,
    REG_LEFT_MIN  = 3'd1,
    REG_LEFT_MAX  = 3'd2,
    REG_RIGHT_MIN = 3'd3,
    REG_RIGHT_MAX = 3'd4,
    REG_TURN_MAX  = 3'd5,
    REG_DRIVE_MAX = 3'd6,
    REG_TIMEOUT   = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    CAUSE_LEFT     = 3'd0,
    CAUSE_RIGHT    = 3'd1,
    CAUSE_FORWARD  = 3'd2,
    CAUSE_BACKWARD = 3'd3,
    CAUSE_STOP     = 3'd4,
    CAUSE_PAN      = 3'd5,
    CAUSE_BAD      = 3'd6,
    CAUSE_TIMEOUT  = 3'd7
  } cause_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  // One result item
  typedef struct packed {
    cause_e     cause;
    logic       link_reset;
    logic       dirs_valid;
    logic [1:0] right_dir;
    logic [1:0] left_dir;
    logic [7:0] speed;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/drive_command_frame_decoder_top.sv =====
// Drive command frame decoder, top level: framing, heartbeat, speed mapping.
// Depends on dcfd_pkg and drive_command_frame_decoder_top_defines.svh.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-------------------------------------
//  s_axis   | in  | tvalid/tready          | tdata: rx_byte; tuser: req_type
//  m_axis   | out | tvalid/tready          | tdata: speed,ldir,rdir,valid,reset;
//           |     |                        | tuser: cause
//  apb      | in  | psel/penable, pready=1 | 8 registers at 4*i, 32-bit data
//
// A tick that does not time out, or a byte that does not complete a frame, passes
// through accept and eval. A timeout tick, a completing byte whose result needs no
// mapping (stop, pan, bad frame), or a turn with an empty angle span goes through
// accept, eval and load. Other turn and drive results add a multiply step and 16
// steps of the restoring divider that divides by the angle or throttle span before
// the load. The output register lets the next item be accepted while a result
// waits; the load cycle stalls only if that register is still full.
// Reset is asynchronous, active low; frame bytes have no reset.
`default_nettype none
`include "drive_command_frame_decoder_top_defines.svh"

module drive_command_frame_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] req_type
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] motor_speed, [9:8] left_dir,
                                             // [11:10] right_dir, [12] dirs_valid,
                                             // [13] link_reset, [15:14] zero
  output logic [2:0]       m_axis_tuser_o,   // [2:0] cause
  // configuration
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [4:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);

  // ---------------- configuration registers ----------------
  logic [7:0]  center_q, lmin_q, lmax_q, rmin_q, rmax_q, tmax_q, dmax_q;
  logic [15:0] timeout_q;
  dcfd_pkg::reg_idx_e cfg_idx;
  logic cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_idx  = dcfd_pkg::reg_idx_e'(paddr_i[4:2]);
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q  <= dcfd_pkg::RstCenter;
      lmin_q    <= dcfd_pkg::RstLeftMin;
      lmax_q    <= dcfd_pkg::RstLeftMax;
      rmin_q    <= dcfd_pkg::RstRightMin;
      rmax_q    <= dcfd_pkg::RstRightMax;
      tmax_q    <= dcfd_pkg::RstTurnMax;
      dmax_q    <= dcfd_pkg::RstDriveMax;
      timeout_q <= dcfd_pkg::RstTimeout;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        dcfd_pkg::REG_CENTER:    center_q  <= pwdata_i[7:0];
        dcfd_pkg::REG_LEFT_MIN:  lmin_q    <= pwdata_i[7:0];
        dcfd_pkg::REG_LEFT_MAX:  lmax_q    <= pwdata_i[7:0];
        dcfd_pkg::REG_RIGHT_MIN: rmin_q    <= pwdata_i[7:0];
        dcfd_pkg::REG_RIGHT_MAX: rmax_q    <= pwdata_i[7:0];
        dcfd_pkg::REG_TURN_MAX:  tmax_q    <= pwdata_i[7:0];
        dcfd_pkg::REG_DRIVE_MAX: dmax_q    <= pwdata_i[7:0];
        dcfd_pkg::REG_TIMEOUT:   timeout_q <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      dcfd_pkg::REG_CENTER:    prdata_o = {24'd0, center_q};
      dcfd_pkg::REG_LEFT_MIN:  prdata_o = {24'd0, lmin_q};
      dcfd_pkg::REG_LEFT_MAX:  prdata_o = {24'd0, lmax_q};
      dcfd_pkg::REG_RIGHT_MIN: prdata_o = {24'd0, rmin_q};
      dcfd_pkg::REG_RIGHT_MAX: prdata_o = {24'd0, rmax_q};
      dcfd_pkg::REG_TURN_MAX:  prdata_o = {24'd0, tmax_q};
      dcfd_pkg::REG_DRIVE_MAX: prdata_o = {24'd0, dmax_q};
      dcfd_pkg::REG_TIMEOUT:   prdata_o = {16'd0, timeout_q};
      default:                 prdata_o = 32'd0;
    endcase
  end

  // ---------------- state ----------------
  dcfd_pkg::state_e state_q, state_d;
  logic        req_q;
  logic [7:0]  rxb_q;
  logic [1:0]  bidx_q, bidx_d;
  logic [7:0]  frame_q [3];
  logic        frame_we;
  logic [dcfd_pkg::ElapsedW-1:0] elapsed_q, elapsed_d, elapsed_inc;

  // mapping operands and divider
  logic signed [8:0] diff_q, diff_d, den_q, den_d, odiff_q, odiff_d;
  logic [7:0]  olo_q, olo_d;
  logic        neg_q, neg_d;
  logic [dcfd_pkg::QuoW-1:0] quo_q, quo_d, quo_nx;
  logic [7:0]  rem_q, rem_d, dvs_q, dvs_d;
  logic [dcfd_pkg::CntW-1:0] cnt_q, cnt_d;
  dcfd_pkg::result_t res_q, res_d, out_q;
  logic        out_valid_q;
  logic        out_load;

  // eval-time helpers
  logic [7:0]  dir_b, thr_b, ang_b;
  logic [7:0]  map_x, map_lo, map_hi, map_olo, map_ohi;
  logic        do_map;
  logic signed [17:0] prod;
  logic [17:0] prod_mag;
  logic [8:0]  trial;
  logic        qbit;
  logic signed [17:0] qs, vsum;

  assign dir_b = frame_q[0];
  assign thr_b = frame_q[1];
  assign ang_b = frame_q[2];
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;

  // shared datapath: multiplier and one restoring divider step
  assign prod     = diff_q * odiff_q;
  assign prod_mag = prod[17] ? 18'(-prod) : 18'(prod);
  assign trial    = {rem_q, quo_q[dcfd_pkg::QuoW-1]};
  assign qbit     = (trial >= {1'b0, dvs_q});
  assign quo_nx   = {quo_q[dcfd_pkg::QuoW-2:0], qbit};

  // signed quotient plus output offset, then clamp to a byte
  always_comb begin
    qs   = neg_q ? -$signed({2'b00, quo_nx}) : $signed({2'b00, quo_nx});
    vsum = qs + $signed({10'd0, olo_q});
  end

  assign s_axis_tready_o = (state_q == dcfd_pkg::ST_IDLE);
  assign out_load = (state_q == dcfd_pkg::ST_DONE) && (!out_valid_q || m_axis_tready_i);

  // sequencer: next state and datapath updates
  always_comb begin
    state_d   = state_q;
    bidx_d    = bidx_q;
    elapsed_d = elapsed_q;
    frame_we  = 1'b0;
    diff_d    = diff_q;
    den_d     = den_q;
    odiff_d   = odiff_q;
    olo_d     = olo_q;
    neg_d     = neg_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    map_x     = ang_b;
    map_lo    = lmin_q;
    map_hi    = lmax_q;
    map_olo   = dcfd_pkg::TurnSpeedMin;
    map_ohi   = tmax_q;
    do_map    = 1'b0;

    unique case (state_q)
      dcfd_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = dcfd_pkg::ST_EVAL;
      end

      dcfd_pkg::ST_EVAL: begin
        state_d = dcfd_pkg::ST_IDLE;
        if (req_q) begin
          // heartbeat tick
          elapsed_d = elapsed_inc;
          if (elapsed_inc > {1'b0, timeout_q}) begin
            elapsed_d = '0;
            bidx_d    = 2'd0;
            res_d     = '{cause: dcfd_pkg::CAUSE_TIMEOUT, link_reset: 1'b1,
                          dirs_valid: 1'b0, right_dir: dcfd_pkg::DirNone,
                          left_dir: dcfd_pkg::DirNone, speed: 8'd0};
            state_d   = dcfd_pkg::ST_DONE;
          end
        end else if (bidx_q != 2'd3) begin
          frame_we = 1'b1;
          bidx_d   = bidx_q + 2'd1;
        end else begin
          // lights byte completes the frame
          bidx_d    = 2'd0;
          elapsed_d = '0;
          state_d   = dcfd_pkg::ST_DONE;
          res_d     = '{cause: dcfd_pkg::CAUSE_BAD, link_reset: 1'b1,
                        dirs_valid: 1'b0, right_dir: dcfd_pkg::DirNone,
                        left_dir: dcfd_pkg::DirNone, speed: 8'd0};
          if (dir_b >= dcfd_pkg::CodeFwd && dir_b <= dcfd_pkg::CodeStop) begin
            res_d.link_reset = 1'b0;
            res_d.dirs_valid = 1'b1;
            if (ang_b < center_q) begin
              do_map          = 1'b1;
              res_d.cause     = dcfd_pkg::CAUSE_LEFT;
              res_d.left_dir  = dcfd_pkg::DirRev;
              res_d.right_dir = dcfd_pkg::DirFwd;
            end else if (ang_b > center_q) begin
              do_map          = 1'b1;
              map_lo          = rmin_q;
              map_hi          = rmax_q;
              res_d.cause     = dcfd_pkg::CAUSE_RIGHT;
              res_d.left_dir  = dcfd_pkg::DirFwd;
              res_d.right_dir = dcfd_pkg::DirRev;
            end else if (dir_b == dcfd_pkg::CodeFwd) begin
              do_map          = 1'b1;
              map_x           = thr_b;
              map_lo          = dcfd_pkg::ForwardThrottleMin;
              map_hi          = dcfd_pkg::ForwardThrottleMax;
              map_olo         = dcfd_pkg::DriveSpeedMin;
              map_ohi         = dmax_q;
              res_d.cause     = dcfd_pkg::CAUSE_FORWARD;
              res_d.left_dir  = dcfd_pkg::DirFwd;
              res_d.right_dir = dcfd_pkg::DirFwd;
            end else if (dir_b == dcfd_pkg::CodeBwd) begin
              do_map          = 1'b1;
              map_x           = thr_b;
              map_lo          = dcfd_pkg::BackwardThrottleMin;
              map_hi          = dcfd_pkg::BackwardThrottleMax;
              map_olo         = dcfd_pkg::DriveSpeedMin;
              map_ohi         = dmax_q;
              res_d.cause     = dcfd_pkg::CAUSE_BACKWARD;
              res_d.left_dir  = dcfd_pkg::DirRev;
              res_d.right_dir = dcfd_pkg::DirRev;
            end else begin
              res_d.cause      = dcfd_pkg::CAUSE_STOP;
              res_d.dirs_valid = 1'b0;
            end
          end else if (dir_b == dcfd_pkg::CodePan || dir_b == dcfd_pkg::CodeStopAll) begin
            res_d.cause      = dcfd_pkg::CAUSE_PAN;
            res_d.link_reset = 1'b0;
          end
          // set up the linear map; an empty input span gives the offset
          if (do_map) begin
            diff_d  = $signed({1'b0, map_x})   - $signed({1'b0, map_lo});
            den_d   = $signed({1'b0, map_hi})  - $signed({1'b0, map_lo});
            odiff_d = $signed({1'b0, map_ohi}) - $signed({1'b0, map_olo});
            olo_d   = map_olo;
            res_d.speed = map_olo;
            if (map_hi != map_lo) state_d = dcfd_pkg::ST_MUL;
          end
        end
      end

      dcfd_pkg::ST_MUL: begin
        quo_d   = prod_mag[dcfd_pkg::QuoW-1:0];
        neg_d   = prod[17] ^ den_q[8];
        dvs_d   = den_q[8] ? 8'(-den_q) : den_q[7:0];
        rem_d   = 8'd0;
        cnt_d   = '0;
        state_d = dcfd_pkg::ST_DIV;
      end

      dcfd_pkg::ST_DIV: begin
        quo_d = quo_nx;
        rem_d = qbit ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == dcfd_pkg::DivLast) begin
          if (vsum < 0)             res_d.speed = 8'd0;
          else if (vsum > 18'sd255) res_d.speed = 8'd255;
          else                      res_d.speed = vsum[7:0];
          state_d = dcfd_pkg::ST_DONE;
        end
      end

      dcfd_pkg::ST_DONE: begin
        if (out_load) state_d = dcfd_pkg::ST_IDLE;
      end

      default: state_d = dcfd_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dcfd_pkg::ST_IDLE;
      bidx_q    <= 2'd0;
      elapsed_q <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      bidx_q    <= bidx_d;
      elapsed_q <= elapsed_d;
      cnt_q     <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      req_q <= s_axis_tuser_i[0];
      rxb_q <= s_axis_tdata_i;
    end
    if (frame_we) frame_q[bidx_q] <= rxb_q;
    diff_q  <= diff_d;
    den_q   <= den_d;
    odiff_q <= odiff_d;
    olo_q   <= olo_d;
    neg_q   <= neg_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    res_q   <= res_d;
    if (out_load) out_q <= res_q;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.link_reset, out_q.dirs_valid, out_q.right_dir,
                            out_q.left_dir, out_q.speed};
  assign m_axis_tuser_o  = out_q.cause;

  // ---------------- assertions ----------------
  `DCFD_ASSERT(a_accept_leaves_idle, (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == dcfd_pkg::ST_EVAL), "accepted item not evaluated")
  `DCFD_ASSERT(a_load_shows_result, out_load |=> m_axis_tvalid_o, "loaded result not presented")
  `DCFD_ASSERT_ALWAYS(a_cnt_idle_zero, (state_q != dcfd_pkg::ST_DIV) |-> (cnt_q == '0), "divider step count nonzero outside division")

endmodule

`default_nettype wire

// ===== tb/sv/drive_command_frame_decoder_top_tb.sv =====
// Self-checking testbench for drive_command_frame_decoder_top: directed frames, then
// random traffic over several register settings, checked against an in-bench decoder.
// Depends on dcfd_pkg and the RTL of drive_command_frame_decoder_top.
`timescale 1ns / 1ps

module drive_command_frame_decoder_top_tb;

  localparam int CycleLimit   = 2_000_000;
  localparam int SettleCycles = 40;
  localparam int HoldCycles   = 400;

  // Clock, reset and block inputs (all known from time zero)
  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic [0:0]  s_tuser  = 1'b0;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = 5'd0;
  logic [31:0] pwdata   = 32'd0;

  logic        s_tready;
  logic        m_tvalid;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic [31:0] prdata;
  logic        pready;

  drive_command_frame_decoder_top u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  // Shadow registers and decoder state
  logic [15:0] cfg_shadow [8];
  logic [1:0]  frm_idx     = 2'd0;
  logic [7:0]  frm_bytes [3];
  logic [16:0] hb_elapsed  = 17'd0;

  dcfd_pkg::result_t motor_cmd_q [$];
  dcfd_pkg::result_t got_cmd;
  int          err_cnt     = 0;
  int          items_sent  = 0;
  int          cycle_cnt   = 0;
  int          idle_pct    = 8;
  int          tick_mix    = 10;
  logic        hold_arm    = 1'b0;
  int          hold_left   = HoldCycles;

  // Directed stimulus table
  typedef struct {
    logic    req_tick;
    logic [7:0] data;
    bit      typed;
    dcfd_pkg::result_t want;
  } stim_row_t;
  stim_row_t stim_tab [$];

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    cfg_shadow[dcfd_pkg::REG_CENTER]    = 16'(dcfd_pkg::RstCenter);
    cfg_shadow[dcfd_pkg::REG_LEFT_MIN]  = 16'(dcfd_pkg::RstLeftMin);
    cfg_shadow[dcfd_pkg::REG_LEFT_MAX]  = 16'(dcfd_pkg::RstLeftMax);
    cfg_shadow[dcfd_pkg::REG_RIGHT_MIN] = 16'(dcfd_pkg::RstRightMin);
    cfg_shadow[dcfd_pkg::REG_RIGHT_MAX] = 16'(dcfd_pkg::RstRightMax);
    cfg_shadow[dcfd_pkg::REG_TURN_MAX]  = 16'(dcfd_pkg::RstTurnMax);
    cfg_shadow[dcfd_pkg::REG_DRIVE_MAX] = 16'(dcfd_pkg::RstDriveMax);
    cfg_shadow[dcfd_pkg::REG_TIMEOUT]   = dcfd_pkg::RstTimeout;
    for (int i = 0; i < 3; i++) frm_bytes[i] = 8'h00;
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  function automatic dcfd_pkg::result_t mk_res(logic [7:0] spd, logic [1:0] ldir,
                                               logic [1:0] rdir, logic dv, logic lr,
                                               dcfd_pkg::cause_e c);
    dcfd_pkg::result_t x;
    x.speed      = spd;
    x.left_dir   = ldir;
    x.right_dir  = rdir;
    x.dirs_valid = dv;
    x.link_reset = lr;
    x.cause      = c;
    return x;
  endfunction

  // Linear map of x from [in_lo, in_hi] onto [out_lo, out_hi], clamped to a byte
  function automatic logic [7:0] span_scale(int x, int in_lo, int in_hi, int out_lo,
                                            int out_hi);
    int v;
    if (in_hi == in_lo) v = out_lo;
    else v = (x - in_lo) * (out_hi - out_lo) / (in_hi - in_lo) + out_lo;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Decoder: framing, heartbeat and speed mapping for one accepted item
  task automatic decode_step(input logic is_tick, input logic [7:0] b,
                             output bit has, output dcfd_pkg::result_t r);
    logic [7:0] d, t, a, ctr;
    int tmax, dmax;
    has  = 1'b0;
    r    = '0;
    ctr  = cfg_shadow[dcfd_pkg::REG_CENTER][7:0];
    tmax = int'(cfg_shadow[dcfd_pkg::REG_TURN_MAX]);
    dmax = int'(cfg_shadow[dcfd_pkg::REG_DRIVE_MAX]);
    if (is_tick) begin
      if (hb_elapsed != '1) hb_elapsed++;
      if (hb_elapsed > {1'b0, cfg_shadow[dcfd_pkg::REG_TIMEOUT]}) begin
        hb_elapsed = '0;
        frm_idx    = 2'd0;
        r   = mk_res(8'd0, dcfd_pkg::DirNone, dcfd_pkg::DirNone, 1'b0, 1'b1,
                     dcfd_pkg::CAUSE_TIMEOUT);
        has = 1'b1;
      end
    end else if (frm_idx < 2'd3) begin
      frm_bytes[frm_idx] = b;
      frm_idx++;
    end else begin
      // lights byte closes the frame
      frm_idx    = 2'd0;
      hb_elapsed = '0;
      d = frm_bytes[0];
      t = frm_bytes[1];
      a = frm_bytes[2];
      has = 1'b1;
      if (d >= dcfd_pkg::CodeFwd && d <= dcfd_pkg::CodeStop) begin
        if (a < ctr)
          r = mk_res(span_scale(int'(a), int'(cfg_shadow[dcfd_pkg::REG_LEFT_MIN]),
                                int'(cfg_shadow[dcfd_pkg::REG_LEFT_MAX]),
                                int'(dcfd_pkg::TurnSpeedMin), tmax),
                     dcfd_pkg::DirRev, dcfd_pkg::DirFwd, 1'b1, 1'b0, dcfd_pkg::CAUSE_LEFT);
        else if (a > ctr)
          r = mk_res(span_scale(int'(a), int'(cfg_shadow[dcfd_pkg::REG_RIGHT_MIN]),
                                int'(cfg_shadow[dcfd_pkg::REG_RIGHT_MAX]),
                                int'(dcfd_pkg::TurnSpeedMin), tmax),
                     dcfd_pkg::DirFwd, dcfd_pkg::DirRev, 1'b1, 1'b0, dcfd_pkg::CAUSE_RIGHT);
        else if (d == dcfd_pkg::CodeFwd)
          r = mk_res(span_scale(int'(t), int'(dcfd_pkg::ForwardThrottleMin),
                                int'(dcfd_pkg::ForwardThrottleMax),
                                int'(dcfd_pkg::DriveSpeedMin), dmax),
                     dcfd_pkg::DirFwd, dcfd_pkg::DirFwd, 1'b1, 1'b0,
                     dcfd_pkg::CAUSE_FORWARD);
        else if (d == dcfd_pkg::CodeBwd)
          r = mk_res(span_scale(int'(t), int'(dcfd_pkg::BackwardThrottleMin),
                                int'(dcfd_pkg::BackwardThrottleMax),
                                int'(dcfd_pkg::DriveSpeedMin), dmax),
                     dcfd_pkg::DirRev, dcfd_pkg::DirRev, 1'b1, 1'b0,
                     dcfd_pkg::CAUSE_BACKWARD);
        else
          r = mk_res(8'd0, dcfd_pkg::DirNone, dcfd_pkg::DirNone, 1'b0, 1'b0,
                     dcfd_pkg::CAUSE_STOP);
      end else if (d == dcfd_pkg::CodePan || d == dcfd_pkg::CodeStopAll) begin
        r = mk_res(8'd0, dcfd_pkg::DirNone, dcfd_pkg::DirNone, 1'b0, 1'b0,
                   dcfd_pkg::CAUSE_PAN);
      end else begin
        r = mk_res(8'd0, dcfd_pkg::DirNone, dcfd_pkg::DirNone, 1'b0, 1'b1,
                   dcfd_pkg::CAUSE_BAD);
      end
    end
  endtask

  // Offer one item, wait for it to be taken, then queue what it should produce
  task automatic push_item(input logic is_tick, input logic [7:0] b, input bit typed,
                           input dcfd_pkg::result_t fixed);
    dcfd_pkg::result_t r;
    bit      has;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= is_tick;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    decode_step(is_tick, b, has, r);
    if (has) motor_cmd_q.push_back(typed ? fixed : r);
  endtask

  task automatic send_frame(input logic [7:0] d, t, a, l);
    logic [7:0] fr [4];
    fr = '{d, t, a, l};
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(99) < tick_mix) push_item(1'b1, 8'($urandom_range(255)), 0, '0);
      push_item(1'b0, fr[i], 0, '0);
    end
  endtask

  task automatic add_frame(input logic [7:0] d, t, a, l, input bit typed,
                           input dcfd_pkg::result_t w);
    stim_tab.push_back('{1'b0, d, 1'b0, '0});
    stim_tab.push_back('{1'b0, t, 1'b0, '0});
    stim_tab.push_back('{1'b0, a, 1'b0, '0});
    stim_tab.push_back('{1'b0, l, typed, w});
  endtask

  // APB write followed by a read back of the same register
  task automatic write_reg(input dcfd_pkg::reg_idx_e ri, input logic [15:0] v);
    logic [31:0] mask;
    logic [31:0] rd;
    mask = (ri == dcfd_pkg::REG_TIMEOUT) ? 32'h0000_FFFF : 32'h0000_00FF;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ri, 2'b00};
    pwdata  <= ($urandom() & ~mask) | ({16'd0, v} & mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cfg_shadow[ri] = v & mask[15:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata & mask;
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("reg_readback", cfg_shadow[ri], rd[15:0]);
  endtask

  task automatic set_all(input int c, lmn, lmx, rmn, rmx, tmax, dmax, tmo);
    write_reg(dcfd_pkg::REG_CENTER, 16'(c));
    write_reg(dcfd_pkg::REG_LEFT_MIN, 16'(lmn));
    write_reg(dcfd_pkg::REG_LEFT_MAX, 16'(lmx));
    write_reg(dcfd_pkg::REG_RIGHT_MIN, 16'(rmn));
    write_reg(dcfd_pkg::REG_RIGHT_MAX, 16'(rmx));
    write_reg(dcfd_pkg::REG_TURN_MAX, 16'(tmax));
    write_reg(dcfd_pkg::REG_DRIVE_MAX, 16'(dmax));
    write_reg(dcfd_pkg::REG_TIMEOUT, 16'(tmo));
  endtask

  // Stop offering, let every result drain, then give a tick in flight time to finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (motor_cmd_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(9))
      0, 1:    return dcfd_pkg::CodeFwd;
      2, 3:    return dcfd_pkg::CodeBwd;
      4:       return dcfd_pkg::CodeStop;
      5:       return dcfd_pkg::CodePan;
      6:       return dcfd_pkg::CodeStopAll;
      7:       return 8'($urandom_range(255));
      8:       return $urandom_range(1) ? dcfd_pkg::CodeFwd - 8'd1
                                        : dcfd_pkg::CodeStopAll + 8'd1;
      default: return dcfd_pkg::CodeFwd + 8'($urandom_range(2));
    endcase
  endfunction

  // Angles cluster on the center and the ends of both mapping ranges
  function automatic logic [7:0] pick_angle();
    logic [7:0] c;
    c = cfg_shadow[dcfd_pkg::REG_CENTER][7:0];
    case ($urandom_range(11))
      0:       return c;
      1:       return c - 8'd1;
      2:       return c + 8'd1;
      3:       return cfg_shadow[dcfd_pkg::REG_LEFT_MIN][7:0];
      4:       return cfg_shadow[dcfd_pkg::REG_LEFT_MAX][7:0];
      5:       return cfg_shadow[dcfd_pkg::REG_RIGHT_MIN][7:0];
      6:       return cfg_shadow[dcfd_pkg::REG_RIGHT_MAX][7:0];
      7:       return 8'h00;
      8:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_throttle();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly whole frames with ticks mixed in; a few stray bytes break the framing
  task automatic random_traffic(input int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(99) < 5)
        push_item(1'b0, 8'($urandom_range(255)), 0, '0);
      else
        send_frame(pick_code(), pick_throttle(), pick_angle(), 8'($urandom_range(255)));
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off once armed
  always @(posedge clk) begin
    if (hold_arm && hold_left != 0) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (hold_arm && hold_left != 0) hold_left <= hold_left - 1;
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (motor_cmd_q.size() == 0) begin
        $error("result with nothing expected: tdata %0h tuser %0h", m_tdata, m_tuser);
        err_cnt++;
      end else begin
        got_cmd = motor_cmd_q.pop_front();
        check_field("motor_speed", got_cmd.speed, m_tdata[7:0]);
        check_field("left_dir", got_cmd.left_dir, m_tdata[9:8]);
        check_field("right_dir", got_cmd.right_dir, m_tdata[11:10]);
        check_field("dirs_valid", got_cmd.dirs_valid, m_tdata[12]);
        check_field("link_reset", got_cmd.link_reset, m_tdata[13]);
        check_field("tdata_pad", 16'd0, m_tdata[15:14]);
        check_field("cause", got_cmd.cause, m_tuser);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("drive_command_frame_decoder_top_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at reset settings
    stim_tab.push_back('{1'b1, 8'hA5, 1'b0, '0});
    add_frame(dcfd_pkg::CodeFwd, 8'hFF, 8'h5A, 8'h00, 1,
              mk_res(8'd255, dcfd_pkg::DirFwd, dcfd_pkg::DirFwd, 1'b1, 1'b0,
                     dcfd_pkg::CAUSE_FORWARD));
    add_frame(dcfd_pkg::CodeBwd, 8'h00, 8'h5A, 8'hFF, 1,
              mk_res(8'd0, dcfd_pkg::DirRev, dcfd_pkg::DirRev, 1'b1, 1'b0,
                     dcfd_pkg::CAUSE_BACKWARD));
    add_frame(dcfd_pkg::CodeStop, 8'h80, 8'h2D, 8'h5A, 0, '0);
    add_frame(dcfd_pkg::CodeFwd, 8'h00, 8'hFF, 8'hFF, 1,
              mk_res(8'd255, dcfd_pkg::DirFwd, dcfd_pkg::DirRev, 1'b1, 1'b0,
                     dcfd_pkg::CAUSE_RIGHT));
    add_frame(dcfd_pkg::CodeStop, 8'hFF, 8'h5A, dcfd_pkg::CodeFwd, 1,
              mk_res(8'd0, dcfd_pkg::DirNone, dcfd_pkg::DirNone, 1'b0, 1'b0,
                     dcfd_pkg::CAUSE_STOP));
    add_frame(dcfd_pkg::CodePan, 8'h12, 8'h34, 8'h56, 1,
              mk_res(8'd0, dcfd_pkg::DirNone, dcfd_pkg::DirNone, 1'b0, 1'b0,
                     dcfd_pkg::CAUSE_PAN));
    add_frame(dcfd_pkg::CodeStopAll, 8'hFF, 8'h00, 8'hFF, 1,
              mk_res(8'd0, dcfd_pkg::DirNone, dcfd_pkg::DirNone, 1'b0, 1'b0,
                     dcfd_pkg::CAUSE_PAN));
    add_frame(dcfd_pkg::CodeFwd - 8'd1, 8'h5A, 8'h5A, 8'h5A, 1,
              mk_res(8'd0, dcfd_pkg::DirNone, dcfd_pkg::DirNone, 1'b0, 1'b1,
                     dcfd_pkg::CAUSE_BAD));
    foreach (stim_tab[i])
      push_item(stim_tab[i].req_tick, stim_tab[i].data, stim_tab[i].typed, stim_tab[i].want);
    random_traffic(180);
    settle();

    // Random settings, short timeout, long receiver hold-off
    set_all($urandom_range(255), $urandom_range(255), $urandom_range(255),
            $urandom_range(255), $urandom_range(255), $urandom_range(255),
            $urandom_range(255), $urandom_range(6));
    tick_mix = 25;
    hold_arm <= 1'b1;
    random_traffic(200);
    settle();

    // All registers at zero: every tick times out, turn spans collapse
    set_all(0, 0, 0, 0, 0, 0, 0, 0);
    tick_mix = 15;
    random_traffic(180);
    settle();

    // All registers at their top
    set_all(255, 255, 255, 255, 255, 255, 255, 65535);
    tick_mix = 10;
    random_traffic(150);
    settle();

    // Random settings with no idling on either side
    idle_pct <= 0;
    set_all($urandom_range(255), $urandom_range(255), $urandom_range(255),
            $urandom_range(255), $urandom_range(255), $urandom_range(255),
            $urandom_range(255), $urandom_range(3, 50));
    tick_mix = 20;
    random_traffic(200);
    settle();

    // Ordinary steering geometry around a random center
    idle_pct <= 8;
    begin
      int c;
      c = $urandom_range(60, 200);
      set_all(c, $urandom_range(0, 30), c - 1, c + 1, $urandom_range(c + 1, 255),
              $urandom_range(255), $urandom_range(255), $urandom_range(10, 200));
    end
    tick_mix = 20;
    random_traffic(200);
    settle();

    if (err_cnt == 0) begin
      $display("drive_command_frame_decoder_top_tb: clean");
    end else begin
      $display("drive_command_frame_decoder_top_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/dcfd_pkg.sv
sv/drive_command_frame_decoder_top.sv
tb/sv/drive_command_frame_decoder_top_tb.sv
